// ===== sv/hst_pkg.sv =====
// Shared types, opcodes and defaults for the handle slot table.
package hst_pkg;

    // Default slot count of the table
    localparam int SLOTS_DEFAULT = 1024;

    // Command opcodes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;

    // Command word
    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] handle_in;
        logic [15:0] descriptor_in;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [31:0] handle_out;
        logic [15:0] descriptor_out;
        logic        success;
    } out_word_t;

endpackage

// ===== sv/handle_slot_table_top.sv =====
// Handle slot table: allocate, release and look up handles in a dual-port slot memory.
//
// A command word is taken when start is high and busy is low; its result word
// appears on result with done high for exactly one cycle, and the receiver
// cannot stall it. Busy stays high until the result word is produced. Every
// slot access is a registered read of the slot memory followed by a check
// cycle that may write the entry back; release and look up make one access,
// while allocate examines candidates one at a time, up to SLOTS of them when
// the table is full. After reset the block is busy while a clearing pass
// marks every slot free.
module handle_slot_table_top
    import hst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  cmd,
    output logic      busy,
    output logic      done,
    output out_word_t result
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] SLOT_MASK = IW'(SLOTS - 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);

    // Sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;
    localparam logic [1:0] ST_CHK   = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [31:0] handle;
        logic [15:0] descriptor;
    } entry_t;

    entry_t mem [SLOTS];
    entry_t rdata;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic [31:0]   cand_reg, cand_next;
    logic [31:0]   next_handle_reg, next_handle_next;
    logic [1:0]    op_reg, op_next;
    logic [15:0]   desc_reg, desc_next;
    logic          done_reg, done_next;
    out_word_t     result_reg, result_next;

    logic          mem_we;
    logic [IW-1:0] wr_addr;
    entry_t        wdata;
    logic [IW-1:0] rd_addr;
    logic          hit;
    logic          free_slot;

    // Slot index of the candidate or the given handle
    assign rd_addr   = cand_reg[IW-1:0] & SLOT_MASK;
    assign hit       = rdata.valid && (rdata.handle == cand_reg);
    assign free_slot = (cand_reg != 32'd0) && !rdata.valid;

    // Sequence the clearing pass and each command
    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        scan_next        = scan_reg;
        cand_next        = cand_reg;
        next_handle_next = next_handle_reg;
        op_next          = op_reg;
        desc_next        = desc_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        mem_we           = 1'b0;
        wr_addr          = rd_addr;
        wdata            = rdata;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we  = 1'b1;
                wr_addr = clr_reg;
                wdata   = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next   = cmd.opcode;
                    desc_next = cmd.descriptor_in;
                    scan_next = '0;
                    if (cmd.opcode == OP_ALLOC)
                    begin
                        cand_next = next_handle_reg;
                    end
                    else
                    begin
                        cand_next = cmd.handle_in;
                    end
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                result_next = '{handle_out: cand_reg, descriptor_out: 16'd0, success: 1'b0};
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (free_slot)
                        begin
                            mem_we           = 1'b1;
                            wdata            = '{valid: 1'b1, handle: cand_reg,
                                                 descriptor: desc_reg};
                            next_handle_next = cand_reg + 32'd1;
                            result_next.success = 1'b1;
                        end
                        else if (scan_reg != LAST_IDX)
                        begin
                            // advance to the next candidate
                            cand_next  = cand_reg + 32'd1;
                            scan_next  = scan_reg + 1'b1;
                            state_next = ST_LOOK;
                            done_next  = 1'b0;
                        end
                        else
                        begin
                            result_next.handle_out = 32'd0;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (hit)
                        begin
                            mem_we      = 1'b1;
                            wdata.valid = 1'b0;
                            result_next.success = 1'b1;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (hit)
                        begin
                            result_next.descriptor_out = rdata.descriptor;
                            result_next.success        = 1'b1;
                        end
                    end
                    default:
                    begin
                        result_next.success = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            next_handle_reg <= 32'd1;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            next_handle_reg <= next_handle_next;
            done_reg        <= done_next;
        end
    end

    // Hold command payload and result word
    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        cand_reg   <= cand_next;
        op_reg     <= op_next;
        desc_reg   <= desc_next;
        result_reg <= result_next;
    end

    // Slot memory: one write and one registered read per cycle; a command
    // never reads an entry in the cycle it is written, so no forwarding
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wdata;
        end
        rdata <= mem[rd_addr];
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A result word follows only a check cycle
    a_done_after_chk: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_CHK))
        else $error("result word without a check cycle");

    // An accepted command starts a slot read
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_LOOK))
        else $error("accepted command did not start a slot read");

    // A successful allocation never hands out handle zero
    a_alloc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.success && op_reg == OP_ALLOC) |-> (result.handle_out != 32'd0))
        else $error("handle zero allocated");

    // The memory is written only by the clearing pass or a check cycle
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CHK || state_reg == ST_CLEAR))
        else $error("slot write outside a check or clear cycle");

    // A failed command returns a zero descriptor
    a_fail_desc: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.success) |-> (result.descriptor_out == 16'd0))
        else $error("nonzero descriptor on failure");

endmodule
